FILE: design/riscv_trap_entry_unit_defines.svh
// Assertion macros shared by the trap entry unit RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef RISCV_TRAP_ENTRY_UNIT_DEFINES_SVH
`define RISCV_TRAP_ENTRY_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// Check prop in the same cycle, outside reset.
`define RTE_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that cond is followed by prop in the next cycle, outside reset.
`define RTE_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);
`else
`define RTE_ASSERT(lbl, clk, rst, prop, msg)
`define RTE_ASSERT_NEXT(lbl, clk, rst, cond, prop, msg)
`endif
`endif

FILE: design/rte_pkg.sv
// Types and constants of the trap entry unit.
// No dependencies; imported by every module of the block.
package rte_pkg;

   typedef logic [3:0]  rte_cause_type;
   typedef logic [1:0]  rte_mode_type;
   typedef logic [2:0]  rte_csr_idx_type;

   // Privilege modes
   localparam rte_mode_type MODE_U = 2'd0;
   localparam rte_mode_type MODE_S = 2'd1;
   localparam rte_mode_type MODE_M = 2'd3;

   // Commands
   localparam logic CMD_QUERY = 1'b0;
   localparam logic CMD_TRAP  = 1'b1;

   // Register indexes
   localparam rte_csr_idx_type CSR_MTVEC   = 3'd0;
   localparam rte_csr_idx_type CSR_STVEC   = 3'd1;
   localparam rte_csr_idx_type CSR_MEDELEG = 3'd2;
   localparam rte_csr_idx_type CSR_MIDELEG = 3'd3;
   localparam rte_csr_idx_type CSR_MIE     = 3'd4;
   localparam rte_csr_idx_type CSR_ILLTVAL = 3'd5;

   // Exception causes that select a particular tval source
   localparam rte_cause_type EXC_IFETCH_FAULT = 4'd1;
   localparam rte_cause_type EXC_ILLEGAL      = 4'd2;
   localparam rte_cause_type EXC_BREAKPOINT   = 4'd3;
   localparam rte_cause_type EXC_LD_MISALIGN  = 4'd4;
   localparam rte_cause_type EXC_LD_FAULT     = 4'd5;
   localparam rte_cause_type EXC_ST_MISALIGN  = 4'd6;
   localparam rte_cause_type EXC_ST_FAULT     = 4'd7;
   localparam rte_cause_type EXC_IFETCH_PAGE  = 4'd12;
   localparam rte_cause_type EXC_LD_PAGE      = 4'd13;
   localparam rte_cause_type EXC_ST_PAGE      = 4'd15;

   // Interrupt priority, highest first: MEI MSI MTI SEI SSI STI UEI USI UTI
   localparam int NUM_IRQ = 9;
   localparam rte_cause_type IRQ_ORDER [NUM_IRQ] = '{
      4'd11, 4'd3, 4'd7, 4'd9, 4'd1, 4'd5, 4'd8, 4'd0, 4'd4
   };

   typedef struct packed {
      logic [63:0] mtvec;
      logic [63:0] stvec;
      logic [15:0] medeleg;
      logic [15:0] mideleg;
      logic [15:0] mie;
      logic        ill_tval_instr;
   } rte_cfg_type;

   typedef struct packed {
      logic          cmd;
      rte_cause_type cause_code;
      logic          is_interrupt;
      logic [63:0]   fault_pc;
      logic [63:0]   trap_value;
      logic [31:0]   instr_word;
      rte_mode_type  cur_mode;
      logic          super_ie;
      logic          machine_ie;
      logic [15:0]   pending_bits;
   } rte_req_type;

   typedef struct packed {
      logic         taken;
      rte_mode_type new_mode;
      logic [63:0]  next_pc;
      logic [63:0]  cause_value;
      logic [63:0]  tval_out;
      rte_mode_type prev_mode;
      logic         new_sie;
      logic         new_spie;
      logic         new_mie;
      logic         new_mpie;
   } rte_rsp_type;

endpackage

FILE: design/rte_csr_regs.sv
// Configuration registers of the trap entry unit (trap vectors, delegation, enables).
// Depends on rte_pkg.
module rte_csr_regs (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  rte_pkg::rte_csr_idx_type wr_index,
   input  logic [63:0]              wr_data,
   output rte_pkg::rte_cfg_type     cfg
);
   import rte_pkg::*;

   rte_cfg_type cfg_ff;
   rte_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_MTVEC:   cfg_in.mtvec          = wr_data;
            CSR_STVEC:   cfg_in.stvec          = wr_data;
            CSR_MEDELEG: cfg_in.medeleg        = wr_data[15:0];
            CSR_MIDELEG: cfg_in.mideleg        = wr_data[15:0];
            CSR_MIE:     cfg_in.mie            = wr_data[15:0];
            CSR_ILLTVAL: cfg_in.ill_tval_instr = wr_data[0];
            default:     cfg_in = cfg_ff; // drop writes to unknown indexes
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/rte_irq_select.sv
// Pending-interrupt selection: mask, global enable and fixed-priority pick.
// Depends on rte_pkg.
module rte_irq_select (
   input  logic                  [15:0] pending_bits,
   input  logic                  [15:0] enable_mask,
   input  logic                  [15:0] irq_deleg,
   input  rte_pkg::rte_mode_type        cur_mode,
   input  logic                         super_ie,
   input  logic                         machine_ie,
   output logic                         found,
   output rte_pkg::rte_cause_type       irq_id
);
   import rte_pkg::*;

   logic [15:0] active;
   logic        s_global_en;
   logic        m_global_en;

   assign s_global_en = (cur_mode == MODE_U) || ((cur_mode == MODE_S) && super_ie);
   assign m_global_en = (cur_mode != MODE_M) || machine_ie;

   // Per-cause take condition, independent of priority
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         active[i] = pending_bits[i] && enable_mask[i] &&
                     (irq_deleg[i] ? s_global_en : m_global_en);
      end
   end

   // Scan from lowest priority up so the highest priority wins
   always_comb begin
      found  = 1'b0;
      irq_id = '0;
      for (int k = NUM_IRQ - 1; k >= 0; k--) begin
         if (active[IRQ_ORDER[k]]) begin
            found  = 1'b1;
            irq_id = IRQ_ORDER[k];
         end
      end
   end

endmodule

FILE: design/rte_trap_logic.sv
// Result computation for one registered request: query or trap entry.
// Depends on rte_pkg and rte_irq_select.
module rte_trap_logic (
   input  rte_pkg::rte_req_type req,
   input  rte_pkg::rte_cfg_type cfg,
   output rte_pkg::rte_rsp_type rsp
);
   import rte_pkg::*;

   logic          irq_found;
   rte_cause_type irq_id;
   logic [15:0]   deleg_reg;
   logic          to_s;
   logic [63:0]   vec;
   logic [63:0]   base;
   logic [63:0]   tval;

   rte_irq_select u_irq_select (
      .pending_bits (req.pending_bits),
      .enable_mask  (cfg.mie),
      .irq_deleg    (cfg.mideleg),
      .cur_mode     (req.cur_mode),
      .super_ie     (req.super_ie),
      .machine_ie   (req.machine_ie),
      .found        (irq_found),
      .irq_id       (irq_id)
   );

   assign deleg_reg = req.is_interrupt ? cfg.mideleg : cfg.medeleg;
   assign to_s      = deleg_reg[req.cause_code] && (req.cur_mode != MODE_M);
   assign vec       = to_s ? cfg.stvec : cfg.mtvec;
   assign base      = {vec[63:2], 2'b00};

   always_comb begin
      tval = '0;
      if (!req.is_interrupt) begin
         unique case (req.cause_code)
            EXC_IFETCH_FAULT, EXC_LD_MISALIGN, EXC_LD_FAULT, EXC_ST_MISALIGN,
            EXC_ST_FAULT, EXC_IFETCH_PAGE, EXC_LD_PAGE, EXC_ST_PAGE:
               tval = req.trap_value;
            EXC_ILLEGAL:
               tval = cfg.ill_tval_instr ? {32'd0, req.instr_word} : 64'd0;
            EXC_BREAKPOINT:
               tval = req.fault_pc;
            default:
               tval = '0;
         endcase
      end
   end

   always_comb begin
      rsp = '0;
      if (req.cmd == CMD_QUERY) begin
         if (irq_found) begin
            rsp.taken       = 1'b1;
            rsp.cause_value = {1'b1, 59'd0, irq_id};
         end
      end else begin
         rsp.taken       = 1'b1;
         rsp.cause_value = {req.is_interrupt, 59'd0, req.cause_code};
         rsp.tval_out    = tval;
         rsp.prev_mode   = req.cur_mode;
         // vectored mode only offsets interrupts
         if (req.is_interrupt && vec[0]) begin
            rsp.next_pc = base + {58'd0, req.cause_code, 2'b00};
         end else begin
            rsp.next_pc = base;
         end
         if (to_s) begin
            rsp.new_mode = MODE_S;
            rsp.new_sie  = 1'b0;
            rsp.new_spie = req.super_ie;
            rsp.new_mie  = req.machine_ie;
            rsp.new_mpie = 1'b0;
         end else begin
            rsp.new_mode = MODE_M;
            rsp.new_sie  = req.super_ie;
            rsp.new_spie = 1'b0;
            rsp.new_mie  = 1'b0;
            rsp.new_mpie = req.machine_ie;
         end
      end
   end

endmodule

FILE: design/riscv_trap_entry_unit.sv
// Trap entry unit: takes one request per cycle and returns one result per request,
// in order, on the result port; a request is held in the input register and its result
// in the result register, from which it is offered.
// Throughput is one item per clock and drops only while the result register is
// held by a stalled consumer; both stages then fill and req_ready falls.
// Configuration writes are always ready and take effect on the next cycle; write
// them only while no request is in flight. Depends on rte_pkg, rte_csr_regs,
// rte_trap_logic and riscv_trap_entry_unit_defines.svh.
`include "riscv_trap_entry_unit_defines.svh"
module riscv_trap_entry_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_cmd,
   input  logic [3:0]  req_cause_code,
   input  logic        req_is_interrupt,
   input  logic [63:0] req_fault_pc,
   input  logic [63:0] req_trap_value,
   input  logic [31:0] req_instr_word,
   input  logic [1:0]  req_cur_mode,
   input  logic        req_super_ie,
   input  logic        req_machine_ie,
   input  logic [15:0] req_pending_bits,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_taken,
   output logic [1:0]  rsp_new_mode,
   output logic [63:0] rsp_next_pc,
   output logic [63:0] rsp_cause_value,
   output logic [63:0] rsp_tval_out,
   output logic [1:0]  rsp_prev_mode,
   output logic        rsp_new_sie,
   output logic        rsp_new_spie,
   output logic        rsp_new_mie,
   output logic        rsp_new_mpie
);
   import rte_pkg::*;

   rte_cfg_type cfg;
   rte_req_type req_ff;
   rte_req_type req_in;
   logic        req_valid_ff;
   logic        req_valid_in;
   rte_rsp_type rsp_ff;
   rte_rsp_type rsp_in;
   rte_rsp_type rsp_calc;
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        out_advance;
   logic        req_xfer;

   assign csr_ready = 1'b1;

   rte_csr_regs u_csr_regs (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_wdata),
      .cfg      (cfg)
   );

   // Result register frees when empty or when its transfer completes
   assign out_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready   = !req_valid_ff || out_advance;
   assign req_xfer    = req_valid && req_ready;

   always_comb begin
      req_in = req_ff;
      if (req_xfer) begin
         req_in.cmd          = req_cmd;
         req_in.cause_code   = req_cause_code;
         req_in.is_interrupt = req_is_interrupt;
         req_in.fault_pc     = req_fault_pc;
         req_in.trap_value   = req_trap_value;
         req_in.instr_word   = req_instr_word;
         req_in.cur_mode     = req_cur_mode;
         req_in.super_ie     = req_super_ie;
         req_in.machine_ie   = req_machine_ie;
         req_in.pending_bits = req_pending_bits;
      end
   end

   assign req_valid_in = req_xfer || (req_valid_ff && !out_advance);

   rte_trap_logic u_trap_logic (
      .req (req_ff),
      .cfg (cfg),
      .rsp (rsp_calc)
   );

   assign rsp_in       = (out_advance && req_valid_ff) ? rsp_calc : rsp_ff;
   assign rsp_valid_in = out_advance ? req_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset
   always_ff @(posedge clock) begin
      req_ff <= req_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_taken       = rsp_ff.taken;
   assign rsp_new_mode    = rsp_ff.new_mode;
   assign rsp_next_pc     = rsp_ff.next_pc;
   assign rsp_cause_value = rsp_ff.cause_value;
   assign rsp_tval_out    = rsp_ff.tval_out;
   assign rsp_prev_mode   = rsp_ff.prev_mode;
   assign rsp_new_sie     = rsp_ff.new_sie;
   assign rsp_new_spie    = rsp_ff.new_spie;
   assign rsp_new_mie     = rsp_ff.new_mie;
   assign rsp_new_mpie    = rsp_ff.new_mpie;

   `RTE_ASSERT(a_ready_low_only_full, clock, reset, !req_ready |-> (req_valid_ff && rsp_valid_ff && !rsp_ready), "req_ready low without a full pipeline")
   `RTE_ASSERT_NEXT(a_stage_moves, clock, reset, req_valid_ff && out_advance, rsp_valid_ff, "registered request did not reach the result register")
   `RTE_ASSERT(a_idle_query_zero, clock, reset, (rsp_valid_ff && !rsp_ff.taken) |-> (rsp_ff.cause_value == 64'd0 && rsp_ff.new_mode == MODE_U), "untaken result carries nonzero fields")
   `RTE_ASSERT(a_status_exclusive, clock, reset, rsp_valid_ff |-> !(rsp_ff.new_sie && rsp_ff.new_spie) && !(rsp_ff.new_mie && rsp_ff.new_mpie), "status bits set on both sides of an entry")

endmodule

FILE: tb/riscv_trap_entry_unit_tb.sv
// Self-checking testbench for riscv_trap_entry_unit: trap entries and interrupt queries.
// Predicts each result from a shadow copy of the CSRs and checks it in order.
// Depends on rte_pkg and the riscv_trap_entry_unit RTL.
module riscv_trap_entry_unit_tb;
   import rte_pkg::*;

   localparam int QUIET_LIMIT     = 4000;
   localparam int RSP_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES   = 4;
   localparam int PHASE_ITEMS     = 140;
   localparam rte_csr_idx_type CSR_SPARE_LO = 3'd6;
   localparam rte_csr_idx_type CSR_SPARE_HI = 3'd7;

   typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_style_type;

   logic        clock;
   logic        reset;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [63:0] csr_wdata;
   logic        req_valid;
   logic        req_ready;
   logic        req_cmd;
   logic [3:0]  req_cause_code;
   logic        req_is_interrupt;
   logic [63:0] req_fault_pc;
   logic [63:0] req_trap_value;
   logic [31:0] req_instr_word;
   logic [1:0]  req_cur_mode;
   logic        req_super_ie;
   logic        req_machine_ie;
   logic [15:0] req_pending_bits;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_taken;
   logic [1:0]  rsp_new_mode;
   logic [63:0] rsp_next_pc;
   logic [63:0] rsp_cause_value;
   logic [63:0] rsp_tval_out;
   logic [1:0]  rsp_prev_mode;
   logic        rsp_new_sie;
   logic        rsp_new_spie;
   logic        rsp_new_mie;
   logic        rsp_new_mpie;

   rte_req_type  req_item;
   rte_rsp_type  rsp_seen;
   rte_cfg_type  trap_cfg;
   rte_rsp_type  entry_q[$];
   rte_rsp_type  want;
   int           mismatches;
   int           quiet_cycles;
   int           burst_left;
   bit           send_steady;
   bit           rsp_hold_req;
   rx_style_type rx_style;
   int           rx_left;
   int           rx_count;

   assign req_cmd          = req_item.cmd;
   assign req_cause_code   = req_item.cause_code;
   assign req_is_interrupt = req_item.is_interrupt;
   assign req_fault_pc     = req_item.fault_pc;
   assign req_trap_value   = req_item.trap_value;
   assign req_instr_word   = req_item.instr_word;
   assign req_cur_mode     = req_item.cur_mode;
   assign req_super_ie     = req_item.super_ie;
   assign req_machine_ie   = req_item.machine_ie;
   assign req_pending_bits = req_item.pending_bits;

   assign rsp_seen = {rsp_taken, rsp_new_mode, rsp_next_pc, rsp_cause_value, rsp_tval_out,
                      rsp_prev_mode, rsp_new_sie, rsp_new_spie, rsp_new_mie, rsp_new_mpie};

   riscv_trap_entry_unit u_dut (.*);

   always #10 clock = ~clock;

   // Expected trap entry or interrupt query outcome under the current CSR shadow.
   function automatic rte_rsp_type predict_entry(rte_req_type r);
      rte_rsp_type   o;
      rte_cause_type irq;
      logic [15:0]   live;
      logic [15:0]   deleg;
      logic [63:0]   vec;
      logic [63:0]   offset;
      logic          en;
      logic          to_s;
      o = '0;
      if (r.cmd == CMD_QUERY) begin
         live = r.pending_bits & trap_cfg.mie;
         for (int i = 0; i < NUM_IRQ; i++) begin
            irq = IRQ_ORDER[i];
            if (live[irq] && !o.taken) begin
               if (trap_cfg.mideleg[irq])
                  en = (r.cur_mode == MODE_S && r.super_ie) || r.cur_mode < MODE_S;
               else
                  en = (r.cur_mode == MODE_M && r.machine_ie) || r.cur_mode < MODE_M;
               if (en) begin
                  o.taken = 1'b1;
                  o.cause_value = {1'b1, 59'd0, irq};
               end
            end
         end
         return o;
      end
      deleg = r.is_interrupt ? trap_cfg.mideleg : trap_cfg.medeleg;
      to_s = deleg[r.cause_code] && r.cur_mode < MODE_M;
      if (!r.is_interrupt) begin
         case (r.cause_code)
            EXC_IFETCH_FAULT, EXC_LD_MISALIGN, EXC_LD_FAULT, EXC_ST_MISALIGN, EXC_ST_FAULT,
            EXC_IFETCH_PAGE, EXC_LD_PAGE, EXC_ST_PAGE: o.tval_out = r.trap_value;
            EXC_ILLEGAL:    o.tval_out = trap_cfg.ill_tval_instr ? {32'd0, r.instr_word} : '0;
            EXC_BREAKPOINT: o.tval_out = r.fault_pc;
            default:        o.tval_out = '0;
         endcase
      end
      vec = to_s ? trap_cfg.stvec : trap_cfg.mtvec;
      offset = (r.is_interrupt && vec[0]) ? {58'd0, r.cause_code, 2'b00} : '0;
      o.taken = 1'b1;
      o.new_mode = to_s ? MODE_S : MODE_M;
      o.next_pc = {vec[63:2], 2'b00} + offset;
      o.cause_value = {r.is_interrupt, 59'd0, r.cause_code};
      o.prev_mode = r.cur_mode;
      if (to_s) begin
         o.new_spie = r.super_ie;
         o.new_mie  = r.machine_ie;
      end else begin
         o.new_sie  = r.super_ie;
         o.new_mpie = r.machine_ie;
      end
      return o;
   endfunction

   function automatic logic [63:0] wide_rand();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic rte_req_type make_item(logic cmd, rte_cause_type cause, logic intr,
                                             rte_mode_type mode, logic sie, logic mie,
                                             logic [15:0] pend);
      rte_req_type r;
      r.cmd = cmd;
      r.cause_code = cause;
      r.is_interrupt = intr;
      r.fault_pc = wide_rand();
      r.trap_value = wide_rand();
      r.instr_word = $urandom;
      r.cur_mode = mode;
      r.super_ie = sie;
      r.machine_ie = mie;
      r.pending_bits = pend;
      return r;
   endfunction

   function automatic rte_req_type rand_item();
      logic [15:0] pend;
      case ($urandom_range(0, 2))
         0:       pend = 16'($urandom);
         1:       pend = 16'($urandom & $urandom & $urandom);
         default: pend = 16'd1 << $urandom_range(0, 15);
      endcase
      return make_item($urandom_range(0, 1) ? CMD_TRAP : CMD_QUERY,
                       4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                       2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                       1'($urandom_range(0, 1)), pend);
   endfunction

   function automatic rte_cfg_type rand_cfg();
      rte_cfg_type c;
      c.mtvec = wide_rand();
      c.stvec = wide_rand();
      c.medeleg = 16'($urandom);
      c.mideleg = 16'($urandom);
      c.mie = $urandom_range(0, 3) == 0 ? 16'hffff : 16'($urandom);
      c.ill_tval_instr = 1'($urandom_range(0, 1));
      return c;
   endfunction

   // Offer one request; unless steady, drop valid for a random gap when the burst runs out.
   task automatic send_item(input rte_req_type it);
      if (burst_left == 0 && !send_steady) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 8);
      end
      req_item <= it;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      if (burst_left > 0)
         burst_left--;
   endtask

   // Step past the last transfer edge so its prediction is queued before waiting.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (entry_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_put(input rte_csr_idx_type idx, input logic [63:0] data);
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Write every CSR back to back; upper bits of narrow registers carry noise.
   task automatic program_csrs(input rte_cfg_type c);
      csr_put(CSR_MTVEC, c.mtvec);
      csr_put(CSR_STVEC, c.stvec);
      csr_put(CSR_MEDELEG, {$urandom, 16'($urandom), c.medeleg});
      csr_put(CSR_MIDELEG, {$urandom, 16'($urandom), c.mideleg});
      csr_put(CSR_MIE, {$urandom, 16'($urandom), c.mie});
      csr_put(CSR_ILLTVAL, {$urandom, 31'($urandom), c.ill_tval_instr});
      if ($urandom_range(0, 1))
         csr_put($urandom_range(0, 1) ? CSR_SPARE_HI : CSR_SPARE_LO, wide_rand());
      csr_valid <= 1'b0;
   endtask

   task automatic test_reset_config();
      for (int i = 0; i < 10; i++)
         send_item(rand_item());
      drain_results();
   endtask

   task automatic test_directed_cases();
      rte_cfg_type c;
      rte_req_type r;
      c.mtvec = 64'hffff_ffff_ffff_fffd;
      c.stvec = 64'h8000_0000_0000_0101;
      c.medeleg = 16'hb3a6;
      c.mideleg = 16'h0222;
      c.mie = 16'hffff;
      c.ill_tval_instr = 1'b1;
      program_csrs(c);
      // every exception cause, with mode cycling through U, S, reserved and M
      for (int i = 0; i < 16; i++) begin
         r = make_item(CMD_TRAP, 4'(i), 1'b0, 2'(i % 4), i[0], i[1], 16'hffff);
         r.fault_pc = i[0] ? '1 : '0;
         r.trap_value = i[0] ? '0 : '1;
         r.instr_word = '1;
         send_item(r);
      end
      // vectored interrupt wrapping past the top, delegated one, reserved mode
      send_item(make_item(CMD_TRAP, 4'd15, 1'b1, MODE_M, 1'b1, 1'b1, '0));
      send_item(make_item(CMD_TRAP, 4'd9, 1'b1, MODE_U, 1'b1, 1'b0, '0));
      send_item(make_item(CMD_TRAP, 4'd7, 1'b1, 2'd2, 1'b0, 1'b1, '0));
      send_item(make_item(CMD_QUERY, 4'd0, 1'b0, MODE_M, 1'b0, 1'b1, 16'hffff));
      send_item(make_item(CMD_QUERY, 4'd0, 1'b0, MODE_M, 1'b1, 1'b0, 16'hffff));
      send_item(make_item(CMD_QUERY, 4'd0, 1'b0, 2'd2, 1'b1, 1'b1, 16'h0222));
      send_item(make_item(CMD_QUERY, 4'd0, 1'b0, MODE_S, 1'b1, 1'b0, 16'h0200));
      send_item(make_item(CMD_QUERY, 4'd0, 1'b0, MODE_U, 1'b1, 1'b1, 16'h0000));
      drain_results();
   endtask

   // Hold the result side off while requests keep coming, then let it all drain.
   task automatic test_output_backpressure();
      send_steady = 1'b1;
      rsp_hold_req = 1'b1;
      for (int i = 0; i < 24; i++)
         send_item(rand_item());
      send_steady = 1'b0;
      drain_results();
   endtask

   task automatic test_config_sweep();
      rte_cfg_type c;
      for (int p = 0; p < 8; p++) begin
         case (p)
            0:       c = '0;
            1:       c = '1;
            default: c = rand_cfg();
         endcase
         program_csrs(c);
         for (int i = 0; i < PHASE_ITEMS; i++)
            send_item(rand_item());
         drain_results();
      end
   endtask

   // Result-side ready: styles change every so often; a hold request wins.
   initial begin
      rsp_ready = 1'b0;
      rx_left = 0;
      rx_count = 0;
      forever begin
         @(posedge clock);
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         if (rx_left == 0) begin
            rx_style = rx_style_type'($urandom_range(0, 3));
            rx_left = $urandom_range(30, 250);
         end
         rx_left--;
         rx_count++;
         case (rx_style)
            RX_OPEN:  rsp_ready <= 1'b1;
            RX_LIGHT: rsp_ready <= $urandom_range(0, 3) != 0;
            RX_HEAVY: rsp_ready <= 1'($urandom_range(0, 1));
            default:  rsp_ready <= (rx_count % 5) < 2;
         endcase
      end
   end

   task automatic check_field(input string name, input logic [63:0] exp, input logic [63:0] act);
      if (act !== exp) begin
         $error("%s: expected %h, got %h", name, exp, act);
         mismatches++;
      end
   endtask

   // Track CSR writes, predict on request transfer, check on result transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_MTVEC:   trap_cfg.mtvec = csr_wdata;
               CSR_STVEC:   trap_cfg.stvec = csr_wdata;
               CSR_MEDELEG: trap_cfg.medeleg = csr_wdata[15:0];
               CSR_MIDELEG: trap_cfg.mideleg = csr_wdata[15:0];
               CSR_MIE:     trap_cfg.mie = csr_wdata[15:0];
               CSR_ILLTVAL: trap_cfg.ill_tval_instr = csr_wdata[0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            entry_q.push_back(predict_entry(req_item));
         if (rsp_valid && rsp_ready) begin
            if (entry_q.size() == 0) begin
               $error("result transfer with no prediction waiting");
               mismatches++;
            end else begin
               want = entry_q.pop_front();
               check_field("taken", 64'(want.taken), 64'(rsp_seen.taken));
               check_field("new_mode", 64'(want.new_mode), 64'(rsp_seen.new_mode));
               check_field("next_pc", want.next_pc, rsp_seen.next_pc);
               check_field("cause_value", want.cause_value, rsp_seen.cause_value);
               check_field("tval_out", want.tval_out, rsp_seen.tval_out);
               check_field("prev_mode", 64'(want.prev_mode), 64'(rsp_seen.prev_mode));
               check_field("new_sie", 64'(want.new_sie), 64'(rsp_seen.new_sie));
               check_field("new_spie", 64'(want.new_spie), 64'(rsp_seen.new_spie));
               check_field("new_mie", 64'(want.new_mie), 64'(rsp_seen.new_mie));
               check_field("new_mpie", 64'(want.new_mpie), 64'(rsp_seen.new_mpie));
            end
         end
         if ((csr_valid && csr_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("riscv_trap_entry_unit_tb: done, errors");
            $finish;
         end
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_item = '0;
      trap_cfg = '0;
      mismatches = 0;
      quiet_cycles = 0;
      burst_left = 0;
      send_steady = 1'b0;
      rsp_hold_req = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_config();
      test_directed_cases();
      test_output_backpressure();
      test_config_sweep();
      if (mismatches == 0)
         $display("riscv_trap_entry_unit_tb: done, clean");
      else
         $display("riscv_trap_entry_unit_tb: done, errors");
      $finish;
   end

endmodule

FILE: filelist.f
+incdir+design
design/rte_pkg.sv
design/rte_csr_regs.sv
design/rte_irq_select.sv
design/rte_trap_logic.sv
design/riscv_trap_entry_unit.sv
tb/riscv_trap_entry_unit_tb.sv
